>>> rtl/llpf_pkg.sv
// ----------------------------------------------------------------------------
// llpf_pkg
// Shared types, constants and helpers for the four-pole ladder low-pass unit.
// ----------------------------------------------------------------------------
package llpf_pkg;

  // default sample width of the audio channels
  localparam int DEF_SAMPLE_WIDTH = 24;

  // internal state and coefficient formats
  localparam int STATE_W    = 32;
  localparam int COEF_FRAC  = 20;
  localparam int P_W        = 21;
  localparam int K_W        = 22;
  localparam int R_W        = 23;

  // configuration port
  localparam int CFG_W      = 23;
  localparam int CFG_IDX_W  = 2;

  // shared multiplier: 33 x 33 signed, 66-bit product
  localparam int OP_W       = 33;
  localparam int PROD_W     = 2 * OP_W;

  // number of one-pole stages in the ladder
  localparam int NUM_POLES  = 4;
  localparam int POLE_IDX_W = $clog2(NUM_POLES);
  localparam int CHAIN_N    = NUM_POLES + 1;
  localparam int CHAIN_IDX_W = $clog2(CHAIN_N);

  // divide by six: multiply by ceil(2^34 / 6), keep bits 34 and up
  localparam logic [OP_W-1:0] DIV6_MAGIC = 33'd2863311531;
  localparam int DIV6_SHIFT = 34;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLE_GAIN      = 2'd0,
    CFG_POLE_FEEDBACK  = 2'd1,
    CFG_RESONANCE_GAIN = 2'd2
  } cfg_idx_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FEED,
    ST_FEED_WB,
    ST_POLE_IN,
    ST_POLE_PREV,
    ST_POLE_FB,
    ST_POLE_WB,
    ST_SQ,
    ST_SQ_WB,
    ST_CUBE,
    ST_CUBE_WB,
    ST_DIV,
    ST_DIV_WB,
    ST_OUT
  } state_t;

  // saturate a wide signed value to the 32-bit state range
  function automatic logic signed [STATE_W-1:0] sat_state(
    input logic signed [PROD_W-1:0] v
  );
    logic [PROD_W-STATE_W:0] hi;
    hi = v[PROD_W-1:STATE_W-1];
    if ((&hi) || !(|hi)) begin
      return v[STATE_W-1:0];
    end else if (v[PROD_W-1]) begin
      return {1'b1, {(STATE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(STATE_W-1){1'b1}}};
    end
  endfunction

endpackage

>>> rtl/ladder_lowpass_filter_unit.sv
// ----------------------------------------------------------------------------
// ladder_lowpass_filter_unit
// Four-pole ladder low-pass filter with resonance feedback and a cubic soft
// clipper, computed on one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel | ports                               | direction
//  --------+-------------------------------------+-----------
//  input   | in_valid, in_ready, in_sample_in    | in
//  result  | out_valid, out_ready, out_sample_out| out
//  config  | cfg_wr_en, cfg_index, cfg_wdata     | in
//
//  From its input beat to a valid result, a sample steps through resonance
//  feedback, each ladder stage in turn, the soft clipper and the load of the
//  output register. The single 33x33 multiplier sets this sequence.
//  in_ready is high only while the sequencer is idle; a new beat is taken
//  while the last result still waits in the output register.
//  A stalled result holds the sequencer in its last state until taken.
//  Synchronous active-low reset clears filter state, p and r, sets k to -1.0.
//
module ladder_lowpass_filter_unit
  import llpf_pkg::*;
#(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] out_sample_out,
  input  logic                           cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_W-1:0]               cfg_wdata
);

  localparam int SAMPLE_FRAC = SAMPLE_WIDTH - 2;
  localparam logic signed [PROD_W-1:0] HALF_COEF   = PROD_W'(1) << (COEF_FRAC - 1);
  localparam logic signed [PROD_W-1:0] HALF_SAMPLE = PROD_W'(1) << (SAMPLE_FRAC - 1);

  // sequencer
  state_t                  state_r, state_nxt;
  logic [POLE_IDX_W-1:0]   pole_idx_r, pole_idx_nxt;

  // coefficients
  logic [P_W-1:0]          p_r;
  logic signed [K_W-1:0]   k_r;
  logic [R_W-1:0]          r_r;

  // chain: entry 0 is the feed value x, entries 1..4 the stage outputs
  logic signed [STATE_W-1:0] chain_r [CHAIN_N];
  // previous inputs of each stage
  logic signed [STATE_W-1:0] prv_r [NUM_POLES];

  logic signed [SAMPLE_WIDTH-1:0] sample_r;
  logic signed [PROD_W-1:0]       prod_r;
  logic signed [PROD_W-1:0]       acc_r;
  logic signed [STATE_W-1:0]      tmp_r;

  logic                           out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_r;

  // combinational datapath
  logic [CHAIN_IDX_W-1:0]    cidx;
  logic signed [STATE_W-1:0] chain_rd;
  logic signed [OP_W-1:0]    mul_a, mul_b;
  logic signed [STATE_W-1:0] feed_res, pole_res, clip_round, clip_res;
  logic signed [PROD_W-1:0]  q_val;
  logic [STATE_W-1:0]        q_mag;
  logic signed [SAMPLE_WIDTH-1:0] out_sat;
  logic                      out_load;

  assign in_ready       = (state_r == ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_load       = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  // chain read address
  always_comb begin
    unique case (state_r)
      ST_POLE_PREV: cidx = CHAIN_IDX_W'(pole_idx_r);
      ST_POLE_FB:   cidx = CHAIN_IDX_W'(pole_idx_r) + CHAIN_IDX_W'(1);
      default:      cidx = CHAIN_IDX_W'(NUM_POLES);
    endcase
  end
  assign chain_rd = chain_r[cidx];

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_FEED: begin
        mul_a = OP_W'(chain_rd);
        mul_b = $signed(OP_W'(r_r));
      end
      ST_POLE_IN: begin
        mul_a = OP_W'(prv_r[pole_idx_r]);
        mul_b = $signed(OP_W'(p_r));
      end
      ST_POLE_PREV: begin
        mul_a = OP_W'(chain_rd);
        mul_b = $signed(OP_W'(p_r));
      end
      ST_POLE_FB: begin
        mul_a = OP_W'(chain_rd);
        mul_b = OP_W'(k_r);
      end
      ST_SQ: begin
        mul_a = OP_W'(chain_rd);
        mul_b = OP_W'(chain_rd);
      end
      ST_CUBE: begin
        mul_a = OP_W'(tmp_r);
        mul_b = OP_W'(chain_rd);
      end
      ST_DIV: begin
        mul_a = tmp_r[STATE_W-1] ? -OP_W'(tmp_r) : OP_W'(tmp_r);
        mul_b = $signed(DIV6_MAGIC);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // rounding, saturation and the clipper division
  always_comb begin
    feed_res   = sat_state(PROD_W'(sample_r) - ((prod_r + HALF_COEF) >>> COEF_FRAC));
    pole_res   = sat_state(((acc_r - prod_r) + HALF_COEF) >>> COEF_FRAC);
    clip_round = sat_state((prod_r + HALF_SAMPLE) >>> SAMPLE_FRAC);
    q_mag      = prod_r[DIV6_SHIFT+STATE_W-1:DIV6_SHIFT];
    q_val      = tmp_r[STATE_W-1] ? -$signed(PROD_W'(q_mag)) : $signed(PROD_W'(q_mag));
    clip_res   = sat_state(PROD_W'(chain_r[NUM_POLES]) - q_val);
  end

  // output saturation to the sample range
  always_comb begin
    logic [STATE_W-SAMPLE_WIDTH:0] hi;
    hi = chain_r[NUM_POLES][STATE_W-1:SAMPLE_WIDTH-1];
    if ((&hi) || !(|hi)) begin
      out_sat = chain_r[NUM_POLES][SAMPLE_WIDTH-1:0];
    end else if (chain_r[NUM_POLES][STATE_W-1]) begin
      out_sat = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    end else begin
      out_sat = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end
  end

  // next state
  always_comb begin
    state_nxt    = state_r;
    pole_idx_nxt = pole_idx_r;
    unique case (state_r)
      ST_IDLE:      if (in_valid) state_nxt = ST_FEED;
      ST_FEED:      state_nxt = ST_FEED_WB;
      ST_FEED_WB: begin
        state_nxt    = ST_POLE_IN;
        pole_idx_nxt = '0;
      end
      ST_POLE_IN:   state_nxt = ST_POLE_PREV;
      ST_POLE_PREV: state_nxt = ST_POLE_FB;
      ST_POLE_FB:   state_nxt = ST_POLE_WB;
      ST_POLE_WB: begin
        if (pole_idx_r == POLE_IDX_W'(NUM_POLES - 1)) begin
          state_nxt = ST_SQ;
        end else begin
          state_nxt    = ST_POLE_IN;
          pole_idx_nxt = pole_idx_r + POLE_IDX_W'(1);
        end
      end
      ST_SQ:        state_nxt = ST_SQ_WB;
      ST_SQ_WB:     state_nxt = ST_CUBE;
      ST_CUBE:      state_nxt = ST_CUBE_WB;
      ST_CUBE_WB:   state_nxt = ST_DIV;
      ST_DIV:       state_nxt = ST_DIV_WB;
      ST_DIV_WB:    state_nxt = ST_OUT;
      ST_OUT:       if (out_load) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      pole_idx_r <= '0;
    end else begin
      state_r    <= state_nxt;
      pole_idx_r <= pole_idx_nxt;
    end
  end

  // coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r <= '0;
      k_r <= -(K_W'(1) <<< COEF_FRAC);
      r_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_POLE_GAIN:      p_r <= cfg_wdata[P_W-1:0];
        CFG_POLE_FEEDBACK:  k_r <= cfg_wdata[K_W-1:0];
        CFG_RESONANCE_GAIN: r_r <= cfg_wdata[R_W-1:0];
        default: ;
      endcase
    end
  end

  // shared multiplier and scratch registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (in_valid && in_ready) begin
      sample_r <= in_sample_in;
    end
    if (state_r == ST_POLE_PREV) begin
      acc_r <= prod_r;
    end else if (state_r == ST_POLE_FB) begin
      acc_r <= acc_r + prod_r;
    end
    if (state_r == ST_SQ_WB || state_r == ST_CUBE_WB) begin
      tmp_r <= clip_round;
    end
  end

  // filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHAIN_N; i++) chain_r[i] <= '0;
      for (int i = 0; i < NUM_POLES; i++) prv_r[i] <= '0;
    end else begin
      case (state_r)
        ST_FEED_WB:   chain_r[0] <= feed_res;
        ST_POLE_PREV: prv_r[pole_idx_r] <= chain_rd;
        ST_POLE_WB:   chain_r[CHAIN_IDX_W'(pole_idx_r) + CHAIN_IDX_W'(1)] <= pole_res;
        ST_DIV_WB:    chain_r[NUM_POLES] <= clip_res;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample_r <= out_sat;
    end
  end

`ifndef ASSERT_OFF
  // no second beat while a sample is being worked on
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while sequencer busy");

  // a result appears only from the output state
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result valid raised outside output state");

  // last ladder stage hands over to the clipper
  a_last_pole: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POLE_WB && pole_idx_r == POLE_IDX_W'(NUM_POLES - 1))
      |=> state_r == ST_SQ)
    else $error("ladder did not end after the fourth stage");
`endif

endmodule

>>> verif/ladder_lowpass_filter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ladder_lowpass_filter_checker
// Watches the config port and both channels of the ladder filter. Each input
// beat runs through a fixed-point ladder predictor. Each output beat is
// compared with the oldest predicted sample.
// ----------------------------------------------------------------------------
module ladder_lowpass_filter_checker
  import llpf_pkg::*;
#(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_in,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] out_sample_out,
  input  logic                           cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_W-1:0]               cfg_wdata,
  output int                             fail_count,
  output int                             outstanding,
  output int                             results_seen
);

  localparam int FRAC        = SAMPLE_WIDTH - 2;
  localparam int CLIP_DIV    = 6;

  // coefficient copies, Q20
  longint coef_p, coef_k, coef_r;
  // ladder state, FRAC fractional bits
  longint st1, st2, st3, st4;
  longint prev_x, prev1, prev2, prev3;

  logic signed [SAMPLE_WIDTH-1:0] expected_samples[$];
  int miss_total    = 0;
  int results_total = 0;

  function automatic longint clamp(input longint v, input int w);
    longint hi, lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // round half up, then drop n fraction bits
  function automatic longint round_frac(input longint v, input int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  // bilinear one-pole section
  function automatic longint pole(input longint x, input longint x_prev,
                                  input longint y_prev);
    return clamp(round_frac(coef_p * x + coef_p * x_prev - coef_k * y_prev,
                            COEF_FRAC), STATE_W);
  endfunction

  // one sample through resonance, four poles and the soft clipper
  function automatic logic signed [SAMPLE_WIDTH-1:0] ladder_step(
    input logic signed [SAMPLE_WIDTH-1:0] s
  );
    longint x, y, sq, cube;
    x    = clamp(longint'(s) - round_frac(coef_r * st4, COEF_FRAC), STATE_W);
    st1  = pole(x, prev_x, st1);
    st2  = pole(st1, prev1, st2);
    st3  = pole(st2, prev2, st3);
    y    = pole(st3, prev3, st4);
    sq   = clamp(round_frac(y * y, FRAC), STATE_W);
    cube = clamp(round_frac(sq * y, FRAC), STATE_W);
    // division truncates toward zero
    st4    = clamp(y - cube / longint'(CLIP_DIV), STATE_W);
    prev_x = x;
    prev1  = st1;
    prev2  = st2;
    prev3  = st3;
    return SAMPLE_WIDTH'(clamp(st4, SAMPLE_WIDTH));
  endfunction

  task automatic flag(input string what);
    miss_total++;
    $error("%s", what);
  endtask

  always @(posedge clk) begin
    logic signed [SAMPLE_WIDTH-1:0] want;
    if (!rst_n) begin
      coef_p = 0;
      coef_k = -(64'sd1 <<< COEF_FRAC);
      coef_r = 0;
      st1 = 0; st2 = 0; st3 = 0; st4 = 0;
      prev_x = 0; prev1 = 0; prev2 = 0; prev3 = 0;
      expected_samples.delete();
    end else begin
      // output beat against the oldest prediction
      if (out_valid && out_ready) begin
        results_total++;
        if (expected_samples.size() == 0) begin
          flag($sformatf("sample_out: expected none, actual %0d", out_sample_out));
        end else begin
          want = expected_samples.pop_front();
          if (out_sample_out !== want)
            flag($sformatf("sample_out: expected %0d, actual %0d",
                           want, out_sample_out));
        end
      end
      // coefficient writes, unknown index ignored
      if (cfg_wr_en) begin
        case (cfg_idx_t'(cfg_index))
          CFG_POLE_GAIN:      coef_p = longint'(cfg_wdata[P_W-1:0]);
          CFG_POLE_FEEDBACK:  coef_k = longint'($signed(cfg_wdata[K_W-1:0]));
          CFG_RESONANCE_GAIN: coef_r = longint'(cfg_wdata[R_W-1:0]);
          default: ;
        endcase
      end
      // input beat
      if (in_valid && in_ready)
        expected_samples.push_back(ladder_step(in_sample_in));
    end
    fail_count   <= miss_total;
    outstanding  <= expected_samples.size();
    results_seen <= results_total;
  end

endmodule

>>> verif/ladder_lowpass_filter_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ladder_lowpass_filter_unit_tb
// Drives samples and coefficient settings into the ladder filter with random
// gaps and output stalls; the checker predicts and compares every sample.
// ----------------------------------------------------------------------------
module ladder_lowpass_filter_unit_tb;
  import llpf_pkg::*;

  localparam int SAMPLE_W    = DEF_SAMPLE_WIDTH;
  localparam int NUM_PHASES  = 6;
  localparam int PHASE_ITEMS = 100;
  localparam int Q20_ONE     = 1 << COEF_FRAC;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  localparam logic [P_W-1:0] P_ZERO = '0;
  localparam logic [P_W-1:0] P_HALF = P_W'(Q20_ONE / 2);
  localparam logic [P_W-1:0] P_ONE  = P_W'(Q20_ONE);
  localparam logic [P_W-1:0] P_TOP  = '1;
  localparam logic [K_W-1:0] K_ZERO   = '0;
  localparam logic [K_W-1:0] K_ONE    = K_W'(Q20_ONE);
  localparam logic [K_W-1:0] K_NEG    = K_W'(-Q20_ONE);
  localparam logic [K_W-1:0] K_TOP    = {1'b0, {(K_W-1){1'b1}}};
  localparam logic [K_W-1:0] K_BOTTOM = {1'b1, {(K_W-1){1'b0}}};
  localparam logic [R_W-1:0] R_ZERO = '0;
  localparam logic [R_W-1:0] R_ONE  = R_W'(Q20_ONE);
  localparam logic [R_W-1:0] R_TOP  = '1;

  logic                       clk;
  logic                       rst_n          = 1'b0;
  logic                       in_valid       = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample_in   = '0;
  logic                       out_valid;
  logic                       out_ready      = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample_out;
  logic                       cfg_wr_en      = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index      = '0;
  logic [CFG_W-1:0]           cfg_wdata      = '0;

  int fail_count, outstanding, results_seen;
  int samples_sent  = 0;
  int settings_used = 0;
  bit quiet         = 1'b0;
  int stall_left    = 0;

  ladder_lowpass_filter_unit #(.SAMPLE_WIDTH(SAMPLE_W)) dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_sample_in,
    .out_valid, .out_ready, .out_sample_out,
    .cfg_wr_en, .cfg_index, .cfg_wdata
  );

  ladder_lowpass_filter_checker #(.SAMPLE_WIDTH(SAMPLE_W)) checker_i (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_sample_in,
    .out_valid, .out_ready, .out_sample_out,
    .cfg_wr_en, .cfg_index, .cfg_wdata,
    .fail_count, .outstanding, .results_seen
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short idle stretches, a few long ones
  function automatic int idle_len();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return $urandom_range(1, 3);
    if (sel < 95) return $urandom_range(4, 20);
    return $urandom_range(30, 120);
  endfunction

  function automatic int next_gap();
    if (quiet || $urandom_range(0, 99) >= 40) return 0;
    return idle_len();
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return SAMPLE_W'($urandom);
    if (sel < 80) return SAMPLE_W'(int'($urandom_range(0, 16383)) - 8192);
    case ($urandom_range(0, 3))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // result side back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < 25) begin
      stall_left = idle_len() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // present one beat and hold it until taken; valid stays high afterwards
  task automatic send_beat(input logic signed [SAMPLE_W-1:0] s, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= s;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
  endtask

  // drop valid and let every predicted sample come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_coefs(input logic [P_W-1:0] p, input logic [K_W-1:0] k,
                               input logic [R_W-1:0] r, input bit poke_spare);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_POLE_GAIN;
    cfg_wdata <= CFG_W'(p);
    @(posedge clk);
    cfg_index <= CFG_POLE_FEEDBACK;
    cfg_wdata <= CFG_W'(k);
    @(posedge clk);
    cfg_index <= CFG_RESONANCE_GAIN;
    cfg_wdata <= CFG_W'(r);
    @(posedge clk);
    // unknown index must leave the coefficients alone
    if (poke_spare) begin
      cfg_index <= CFG_SPARE;
      cfg_wdata <= '1;
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  task automatic pick_setting(output logic [P_W-1:0] p, output logic [K_W-1:0] k,
                              output logic [R_W-1:0] r);
    int unsigned sel;
    int pv;
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      // well-behaved: k = 2p - 1
      pv = $urandom_range(0, Q20_ONE);
      p  = P_W'(pv);
      k  = K_W'(2 * pv - Q20_ONE);
      r  = R_W'($urandom_range(0, 4 * Q20_ONE));
    end else if (sel < 85) begin
      p = P_W'($urandom);
      k = K_W'($urandom);
      r = R_W'($urandom);
    end else begin
      p = $urandom_range(0, 1) ? P_TOP : P_ZERO;
      case ($urandom_range(0, 2))
        0:       k = K_BOTTOM;
        1:       k = K_TOP;
        default: k = K_NEG;
      endcase
      r = $urandom_range(0, 1) ? R_TOP : R_ZERO;
    end
  endtask

  initial begin
    logic [P_W-1:0] p;
    logic [K_W-1:0] k;
    logic [R_W-1:0] r;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset coefficients keep the ladder at zero
    send_beat(S_MAX, 0);
    send_beat(S_MIN, 2);
    send_beat(SAMPLE_W'(12345), 0);

    // unity gain and feedback, no resonance
    wait_idle();
    program_coefs(P_ONE, K_ONE, R_ZERO, 1'b0);
    send_beat(S_MAX, 0);
    send_beat(S_MAX, 0);
    send_beat(S_MIN, 1);
    send_beat(S_MIN, 0);
    send_beat('0, 0);
    send_beat('1, 3);
    send_beat(SAMPLE_W'(1), 0);
    send_beat(S_MAX, 0);

    // half gain, zero feedback, unity resonance, clipper mid-range
    wait_idle();
    program_coefs(P_HALF, K_ZERO, R_ONE, 1'b0);
    send_beat(S_MAX, 0);
    send_beat(S_MIN, 0);
    send_beat(SAMPLE_W'(24'h200000), 0);
    send_beat(S_MAX, 0);

    // out-of-range coefficients drive the ladder onto the rails
    wait_idle();
    program_coefs(P_TOP, K_BOTTOM, R_TOP, 1'b1);
    send_beat(S_MAX, 0);
    send_beat(S_MIN, 0);
    send_beat(S_MAX, 0);
    send_beat(S_MIN, 0);
    send_beat('0, 0);

    // largest positive feedback
    wait_idle();
    program_coefs(P_ONE, K_TOP, R_ZERO, 1'b0);
    send_beat(S_MAX, 0);
    send_beat(S_MIN, 0);
    send_beat(S_MAX, 0);
    send_beat('0, 0);

    // random phases, one without any idling
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      pick_setting(p, k, r);
      program_coefs(p, k, r, ph == 2);
      quiet <= (ph == 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 3 && i == PHASE_ITEMS / 2) wait_idle();
        send_beat(pick_sample(), next_gap());
      end
    end

    // drain and let any stray beat show up
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("ladder run: %0d samples in, %0d checked, %0d coefficient settings",
             samples_sent, results_seen, settings_used);
    $display("covered sample rails, out-of-range coefficients, spare index writes, stalls");
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> ladder_lowpass_filter_unit.f
rtl/llpf_pkg.sv
rtl/ladder_lowpass_filter_unit.sv
verif/ladder_lowpass_filter_checker.sv
verif/ladder_lowpass_filter_unit_tb.sv
